// ===== rtl/gain_scheduled_pd_steering_macros.svh =====
// ----------------------------------------------------------------------------
// gain scheduled pd steering: assertion macros
// Clocked assertion shorthands used by the steering controller top level.
// ----------------------------------------------------------------------------
`ifndef GAIN_SCHEDULED_PD_STEERING_MACROS_SVH
`define GAIN_SCHEDULED_PD_STEERING_MACROS_SVH

// checked only outside reset
`define GSP_ASSERT_CLK(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) expr) \
      else $error(msg);

// checked on every edge, reset included
`define GSP_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) expr) \
      else $error(msg);

`endif

// ===== rtl/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// Types, widths and constants of the gain scheduled pd steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

   localparam int ERR_W         = 9;
   localparam int HISTORY_DEPTH = 3;
   localparam int SPEED_W       = 12;
   localparam int GAIN_W        = 16;

   // 3*e0 - 2*e1 - e3 stays within six error magnitudes
   localparam int D5_W  = ERR_W + 3;
   localparam int PKP_W = GAIN_W + ERR_W + 1;
   localparam int PKD_W = GAIN_W + D5_W + 1;
   localparam int SUM_W = PKD_W + 2;
   localparam int X_W   = SUM_W - 8;
   localparam int T1_W  = PKP_W - 8;

   // floor(x / 5) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**X_W
   localparam int RECIP_SHIFT = X_W + 3;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5;
   localparam int RECIP_W = $clog2(RECIP + 1);

   localparam int PULSE_W  = 10;
   localparam int OFFSET_W = 8;
   localparam int SE_W     = 15;

   localparam int CENTER_PULSE  = 753;
   localparam int PULSE_SWING   = 89;
   localparam int PULSE_MIN     = CENTER_PULSE - PULSE_SWING;
   localparam int PULSE_MAX     = CENTER_PULSE + PULSE_SWING;
   localparam int BIG_LIMIT     = 110;
   localparam int MID_LIMIT     = 35;
   localparam int SE_MAX        = 32767;
   localparam int THRESH_RESET  = 375;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_KP        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_KD        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSED_LOOP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_BOOST     = 3'd5;

   typedef enum logic [1:0] {
      SLOT_SMALL,
      SLOT_MID,
      SLOT_BIG
   } gain_slot_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] line_position;
      logic [SPEED_W-1:0]      speed;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0]         servo_pulse;
      logic signed [OFFSET_W-1:0] steering_offset;
      logic [SE_W-1:0]            speed_error;
      logic                       speed_error_valid;
   } rsp_type;

   typedef struct packed {
      logic [3*GAIN_W-1:0] servo_kp;
      logic [3*GAIN_W-1:0] servo_kd;
      logic [4*GAIN_W-1:0] motor_gain;
      logic [SPEED_W-1:0]  speed_threshold;
      logic                closed_loop;
      logic                speed_boost;
   } cfg_type;

   // after gain choice
   typedef struct packed {
      logic signed [ERR_W-1:0] e0;
      logic signed [D5_W-1:0]  d5;
      logic [GAIN_W-1:0]       kp;
      logic [GAIN_W-1:0]       kd;
      logic [GAIN_W-1:0]       motor_kp;
      logic [GAIN_W-1:0]       motor_kd;
      logic                    boost;
   } sched_type;

   // raw products
   typedef struct packed {
      logic signed [PKP_W-1:0] p_kp;
      logic signed [PKD_W-1:0] p_kd;
      logic signed [PKP_W-1:0] m_kp;
      logic signed [PKD_W-1:0] m_kd;
      logic                    boost;
   } prod_type;

   // magnitudes divided by 256
   typedef struct packed {
      logic             pd_neg;
      logic [X_W-1:0]   pd_x;
      logic [T1_W-1:0]  t1;
      logic [X_W-1:0]   t2_x;
      logic             boost;
   } mag_type;

   // magnitudes divided by 1280, t1 still divided by 256
   typedef struct packed {
      logic             pd_neg;
      logic [X_W-1:0]   pd_q;
      logic [T1_W-1:0]  t1;
      logic [X_W-1:0]   t2_q;
      logic             boost;
   } quot_type;

endpackage

`default_nettype wire

// ===== rtl/gsp_sched.sv =====
// ----------------------------------------------------------------------------
// gsp_sched
// Input register: gain choice, error history, motor gain state, derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_sched
   import gsp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output sched_type      out_data
);

   logic signed [ERR_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [GAIN_W-1:0]       motor_kp_ff;
   logic [GAIN_W-1:0]       motor_kp_in;
   logic [GAIN_W-1:0]       motor_kd_ff;
   logic [GAIN_W-1:0]       motor_kd_in;
   logic                    valid_ff;
   sched_type               data_ff;
   sched_type               data_in;
   logic                    stage_free;
   logic                    accept;
   logic                    sched_on;
   logic [ERR_W-1:0]        abs_e0;
   gain_slot_type           slot;
   logic signed [ERR_W-1:0] e0;

   always_comb begin
      stage_free = !valid_ff || out_ready;
      req_stall  = !stage_free;
      accept     = req_valid && stage_free;

      e0       = req_data.line_position;
      abs_e0   = e0[ERR_W-1] ? ERR_W'(-e0) : ERR_W'(e0);
      sched_on = cfg.closed_loop && (req_data.speed > cfg.speed_threshold);

      if (!sched_on) begin
         slot = SLOT_SMALL;
      end else if (abs_e0 > ERR_W'(BIG_LIMIT)) begin
         slot = SLOT_BIG;
      end else if (abs_e0 > ERR_W'(MID_LIMIT)) begin
         slot = SLOT_MID;
      end else begin
         slot = SLOT_SMALL;
      end

      // motor gains only move while scheduling is active; mid uses the big set
      motor_kp_in = motor_kp_ff;
      motor_kd_in = motor_kd_ff;
      if (sched_on) begin
         if (slot == SLOT_SMALL) begin
            motor_kp_in = cfg.motor_gain[GAIN_W-1:0];
            motor_kd_in = cfg.motor_gain[2*GAIN_W-1:GAIN_W];
         end else begin
            motor_kp_in = cfg.motor_gain[3*GAIN_W-1:2*GAIN_W];
            motor_kd_in = cfg.motor_gain[4*GAIN_W-1:3*GAIN_W];
         end
      end

      unique case (slot)
         SLOT_SMALL: begin
            data_in.kp = cfg.servo_kp[GAIN_W-1:0];
            data_in.kd = cfg.servo_kd[GAIN_W-1:0];
         end
         SLOT_MID: begin
            data_in.kp = cfg.servo_kp[2*GAIN_W-1:GAIN_W];
            data_in.kd = cfg.servo_kd[2*GAIN_W-1:GAIN_W];
         end
         SLOT_BIG: begin
            data_in.kp = cfg.servo_kp[3*GAIN_W-1:2*GAIN_W];
            data_in.kd = cfg.servo_kd[3*GAIN_W-1:2*GAIN_W];
         end
         default: begin
            data_in.kp = cfg.servo_kp[GAIN_W-1:0];
            data_in.kd = cfg.servo_kd[GAIN_W-1:0];
         end
      endcase

      data_in.e0 = e0;
      // five times the weighted derivative: 3*e0 - 2*e1 - e3
      data_in.d5 = (D5_W'(e0) <<< 1) + D5_W'(e0)
                 - (D5_W'(hist_ff[0]) <<< 1) - D5_W'(hist_ff[2]);
      data_in.motor_kp = motor_kp_in;
      data_in.motor_kd = motor_kd_in;
      data_in.boost    = cfg.speed_boost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         motor_kp_ff <= '0;
         motor_kd_ff <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (stage_free) begin
            valid_ff <= req_valid;
         end
         if (accept) begin
            motor_kp_ff <= motor_kp_in;
            motor_kd_ff <= motor_kd_in;
            hist_ff[0]  <= e0;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/gsp_mult.sv =====
// ----------------------------------------------------------------------------
// gsp_mult
// Product stage: servo and motor gain products, one multiplier each.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_mult
   import gsp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire sched_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output prod_type       out_data
);

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;
   logic     stage_free;

   always_comb begin
      stage_free = !valid_ff || out_ready;
      in_ready   = stage_free;

      data_in.p_kp  = PKP_W'($signed({1'b0, in_data.kp})) * PKP_W'(in_data.e0);
      data_in.p_kd  = PKD_W'($signed({1'b0, in_data.kd})) * PKD_W'(in_data.d5);
      data_in.m_kp  = PKP_W'($signed({1'b0, in_data.motor_kp})) * PKP_W'(in_data.e0);
      data_in.m_kd  = PKD_W'($signed({1'b0, in_data.motor_kd})) * PKD_W'(in_data.d5);
      data_in.boost = in_data.boost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_free) begin
         valid_ff <= in_valid;
      end
      if (stage_free && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/gsp_scale.sv =====
// ----------------------------------------------------------------------------
// gsp_scale
// Two stages: pd sum and magnitudes over 256, then divide by five by
// reciprocal multiply, giving truncation toward zero over 1280.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_scale
   import gsp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire prod_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output quot_type      out_data
);

   localparam int RP_W = X_W + RECIP_W;

   logic                    mag_valid_ff;
   mag_type                 mag_ff;
   mag_type                 mag_in;
   logic                    quot_valid_ff;
   quot_type                quot_ff;
   quot_type                quot_in;
   logic                    mag_free;
   logic                    quot_free;
   logic signed [SUM_W-1:0] pd_sum;
   logic [SUM_W-1:0]        pd_abs;
   logic [PKP_W-1:0]        m_kp_abs;
   logic [PKD_W-1:0]        m_kd_abs;
   logic [RP_W-1:0]         pd_prod;
   logic [RP_W-1:0]         t2_prod;

   always_comb begin
      quot_free = !quot_valid_ff || out_ready;
      mag_free  = !mag_valid_ff || quot_free;
      in_ready  = mag_free;

      pd_sum = (SUM_W'(in_data.p_kp) <<< 2) + SUM_W'(in_data.p_kp)
             + SUM_W'(in_data.p_kd);
      pd_abs   = pd_sum[SUM_W-1] ? SUM_W'(-pd_sum) : SUM_W'(pd_sum);
      m_kp_abs = in_data.m_kp[PKP_W-1] ? PKP_W'(-in_data.m_kp) : PKP_W'(in_data.m_kp);
      m_kd_abs = in_data.m_kd[PKD_W-1] ? PKD_W'(-in_data.m_kd) : PKD_W'(in_data.m_kd);

      mag_in.pd_neg = pd_sum[SUM_W-1];
      mag_in.pd_x   = pd_abs[SUM_W-1:8];
      mag_in.t1     = m_kp_abs[PKP_W-1:8];
      mag_in.t2_x   = X_W'(m_kd_abs[PKD_W-1:8]);
      mag_in.boost  = in_data.boost;

      pd_prod = RP_W'(mag_ff.pd_x) * RP_W'(RECIP);
      t2_prod = RP_W'(mag_ff.t2_x) * RP_W'(RECIP);

      quot_in.pd_neg = mag_ff.pd_neg;
      quot_in.pd_q   = X_W'(pd_prod >> RECIP_SHIFT);
      quot_in.t1     = mag_ff.t1;
      quot_in.t2_q   = X_W'(t2_prod >> RECIP_SHIFT);
      quot_in.boost  = mag_ff.boost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else begin
         if (mag_free) begin
            mag_valid_ff <= in_valid;
         end
         if (quot_free) begin
            quot_valid_ff <= mag_valid_ff;
         end
      end
      if (mag_free && in_valid) begin
         mag_ff <= mag_in;
      end
      if (quot_free && mag_valid_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = quot_valid_ff;
   assign out_data  = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/gain_scheduled_pd_steering.sv =====
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering
// Gain scheduled PD steering controller with speed-error magnitude.
// Throughput: one item per cycle while the result is not stalled; five
// registered stages, each with its own valid, so a stalled result only
// blocks once every stage is occupied.
// Reset: synchronous; clears history, motor gains, held speed error and
// registers (speed threshold 375, others zero); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gain_scheduled_pd_steering_macros.svh"

module gain_scheduled_pd_steering
   import gsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   sched_type  sched_data;
   logic       sched_valid;
   logic       mult_ready;
   prod_type   prod_data;
   logic       prod_valid;
   logic       scale_ready;
   quot_type   quot_data;
   logic       quot_valid;
   logic       out_free;

   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;
   logic [SE_W-1:0]            speed_error_held_ff;
   logic [SE_W-1:0]            speed_error_held_in;
   logic [OFFSET_W-1:0]        swing;
   logic signed [OFFSET_W-1:0] offset;
   logic [X_W:0]               se_sum;
   logic [SE_W-1:0]            se_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_kp        <= '0;
         cfg_ff.servo_kd        <= '0;
         cfg_ff.motor_gain      <= '0;
         cfg_ff.speed_threshold <= SPEED_W'(THRESH_RESET);
         cfg_ff.closed_loop     <= 1'b0;
         cfg_ff.speed_boost     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SERVO_KP:        cfg_ff.servo_kp        <= csr_wdata[3*GAIN_W-1:0];
            CSR_SERVO_KD:        cfg_ff.servo_kd        <= csr_wdata[3*GAIN_W-1:0];
            CSR_MOTOR_GAIN:      cfg_ff.motor_gain      <= csr_wdata[4*GAIN_W-1:0];
            CSR_SPEED_THRESHOLD: cfg_ff.speed_threshold <= csr_wdata[SPEED_W-1:0];
            CSR_CLOSED_LOOP:     cfg_ff.closed_loop     <= csr_wdata[0];
            CSR_SPEED_BOOST:     cfg_ff.speed_boost     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   gsp_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_valid (sched_valid),
      .out_ready (mult_ready),
      .out_data  (sched_data)
   );

   gsp_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sched_valid),
      .in_ready  (mult_ready),
      .in_data   (sched_data),
      .out_valid (prod_valid),
      .out_ready (scale_ready),
      .out_data  (prod_data)
   );

   gsp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (scale_ready),
      .in_data   (prod_data),
      .out_valid (quot_valid),
      .out_ready (out_free),
      .out_data  (quot_data)
   );

   // output stage: clamp, offset, saturating speed error
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;

      swing  = (quot_data.pd_q > X_W'(PULSE_SWING)) ? OFFSET_W'(PULSE_SWING)
                                                    : OFFSET_W'(quot_data.pd_q);
      offset = quot_data.pd_neg ? -$signed(swing) : $signed(swing);

      se_sum = (X_W+1)'(quot_data.t1) + (X_W+1)'(quot_data.t2_q);
      se_new = (se_sum > (X_W+1)'(SE_MAX)) ? SE_W'(SE_MAX) : SE_W'(se_sum);

      speed_error_held_in = quot_data.boost ? se_new : speed_error_held_ff;

      rsp_in.servo_pulse       = PULSE_W'(CENTER_PULSE) + PULSE_W'(offset);
      rsp_in.steering_offset   = offset;
      rsp_in.speed_error       = speed_error_held_in;
      rsp_in.speed_error_valid = quot_data.boost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff        <= 1'b0;
         speed_error_held_ff <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= quot_valid;
         end
         if (out_free && quot_valid) begin
            speed_error_held_ff <= speed_error_held_in;
         end
      end
      if (out_free && quot_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GSP_ASSERT_CLK(a_pulse_range, rsp_valid |-> (rsp_data.servo_pulse >= PULSE_W'(PULSE_MIN)) && (rsp_data.servo_pulse <= PULSE_W'(PULSE_MAX)), "servo pulse outside clamp range")
   `GSP_ASSERT_CLK(a_offset_match, rsp_valid |-> (rsp_data.servo_pulse == PULSE_W'(CENTER_PULSE) + PULSE_W'(rsp_data.steering_offset)), "steering offset does not match pulse")
   `GSP_ASSERT_CLK(a_held_match, rsp_valid |-> (rsp_data.speed_error == speed_error_held_ff), "speed error differs from held value")
   `GSP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

// ===== verif/gain_scheduled_pd_steering_tb.sv =====
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering_tb
// Self-checking bench for the gain scheduled PD steering controller. Drives
// line-position and speed ticks with random idling on both channels, runs
// through a series of register settings, and compares every result transfer
// against an in-bench model of the gain choice, PD sum, clamp and speed error.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gain_scheduled_pd_steering_tb;
   import gsp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int PHASES         = 9;
   localparam int PHASE_ITEMS    = 100;
   localparam int RESET_ITEMS    = 8;
   localparam int DIRECTED_ITEMS = 20;
   localparam int IDLE_PCT       = 27;
   localparam int HOLDOFF_AT     = 400;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int STEADY_FROM    = 600;
   localparam int STEADY_TO      = 700;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_NS     = 200000;

   // model of the controller plus the queue of pending steering commands
   class steering_tracker;
      cfg_type                 cfg;
      logic signed [ERR_W-1:0] err_hist [HISTORY_DEPTH];
      logic [GAIN_W-1:0]       motor_kp;
      logic [GAIN_W-1:0]       motor_kd;
      logic [SE_W-1:0]         se_held;
      rsp_type                 expected_cmds [$];
      int                      mismatches;

      function new();
         cfg = '0;
         cfg.speed_threshold = SPEED_W'(THRESH_RESET);
         foreach (err_hist[i]) err_hist[i] = '0;
         motor_kp   = '0;
         motor_kd   = '0;
         se_held    = '0;
         mismatches = 0;
      endfunction

      function longint magnitude(longint x);
         return (x < 0) ? -x : x;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SERVO_KP:        cfg.servo_kp        = data[3*GAIN_W-1:0];
            CSR_SERVO_KD:        cfg.servo_kd        = data[3*GAIN_W-1:0];
            CSR_MOTOR_GAIN:      cfg.motor_gain      = data[4*GAIN_W-1:0];
            CSR_SPEED_THRESHOLD: cfg.speed_threshold = data[SPEED_W-1:0];
            CSR_CLOSED_LOOP:     cfg.closed_loop     = data[0];
            CSR_SPEED_BOOST:     cfg.speed_boost     = data[0];
            default: ;
         endcase
      endfunction

      function rsp_type predict_tick(req_type item);
         longint        e0, d5, kp, kd, pd, pulse, offset, se;
         gain_slot_type slot;
         rsp_type       r;
         e0   = longint'(item.line_position);
         slot = SLOT_SMALL;
         if (cfg.closed_loop && item.speed > cfg.speed_threshold) begin
            if (magnitude(e0) > BIG_LIMIT) slot = SLOT_BIG;
            else if (magnitude(e0) > MID_LIMIT) slot = SLOT_MID;
            // mid-size error still takes the big motor gains
            if (slot == SLOT_SMALL) begin
               motor_kp = cfg.motor_gain[GAIN_W-1:0];
               motor_kd = cfg.motor_gain[2*GAIN_W-1:GAIN_W];
            end else begin
               motor_kp = cfg.motor_gain[3*GAIN_W-1:2*GAIN_W];
               motor_kd = cfg.motor_gain[4*GAIN_W-1:3*GAIN_W];
            end
         end
         kp = longint'(cfg.servo_kp[GAIN_W*int'(slot) +: GAIN_W]);
         kd = longint'(cfg.servo_kd[GAIN_W*int'(slot) +: GAIN_W]);
         // five times the weighted derivative
         d5 = 3 * e0 - 2 * longint'(err_hist[0]) - longint'(err_hist[2]);
         pd = (5 * kp * e0 + kd * d5) / 1280;
         pulse = CENTER_PULSE + pd;
         if (pulse > PULSE_MAX) pulse = PULSE_MAX;
         if (pulse < PULSE_MIN) pulse = PULSE_MIN;
         r.speed_error_valid = cfg.speed_boost;
         if (cfg.speed_boost) begin
            se = magnitude(longint'(motor_kp) * e0) / 256
               + magnitude(longint'(motor_kd) * d5) / 1280;
            if (se > SE_MAX) se = SE_MAX;
            se_held = se[SE_W-1:0];
         end
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
         err_hist[0] = item.line_position;
         offset = pulse - CENTER_PULSE;
         r.servo_pulse     = pulse[PULSE_W-1:0];
         r.steering_offset = offset[OFFSET_W-1:0];
         r.speed_error     = se_held;
         return r;
      endfunction

      function void note_tick(req_type item);
         expected_cmds.push_back(predict_tick(item));
      endfunction

      function void check_cmd(rsp_type got);
         rsp_type want;
         if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result: servo_pulse %0d steering_offset %0d speed_error %0d",
                        got.servo_pulse, got.steering_offset, got.speed_error);
            end
            return;
         end
         want = expected_cmds.pop_front();
         if (got.servo_pulse !== want.servo_pulse ||
             got.steering_offset !== want.steering_offset ||
             got.speed_error !== want.speed_error ||
             got.speed_error_valid !== want.speed_error_valid) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: servo_pulse exp %0d got %0d, steering_offset exp %0d got %0d",
                        want.servo_pulse, got.servo_pulse,
                        want.steering_offset, got.steering_offset);
               $display("          speed_error exp %0d got %0d, speed_error_valid exp %0b got %0b",
                        want.speed_error, got.speed_error,
                        want.speed_error_valid, got.speed_error_valid);
            end
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   steering_tracker tracker;
   int              sent_count   = 0;
   bit              steady_run   = 1'b0;
   bit              holdoff_done = 1'b0;

   int dir_pos [DIRECTED_ITEMS] = '{0, 255, -255, -256, 110, 111, -111, 35, 36, -36,
                                    -35, 111, 111, 20, -20, 255, -256, 255, -256, 0};
   int dir_spd [DIRECTED_ITEMS] = '{0, 4095, 4095, 4095, 376, 376, 376, 376, 376, 376,
                                    376, 375, 0, 4095, 4095, 4095, 4095, 4095, 4095, 4095};

   gain_scheduled_pd_steering dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_cmd(rsp_data);
   end

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 3))
         0: return GAIN_W'($urandom_range(0, 'h0100));
         1: return GAIN_W'($urandom_range(0, 'h0400));
         2: return GAIN_W'($urandom_range(0, 'h2000));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [ERR_W-1:0] random_line();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 80)) - 40;
         4, 5: begin
            v = int'($urandom_range(MID_LIMIT - 1, MID_LIMIT + 2));
            if ($urandom_range(0, 1)) v = -v;
         end
         6: begin
            v = int'($urandom_range(BIG_LIMIT - 1, BIG_LIMIT + 2));
            if ($urandom_range(0, 1)) v = -v;
         end
         9: begin
            case ($urandom_range(0, 3))
               0: v = -(1 << (ERR_W - 1));
               1: v = -(1 << (ERR_W - 1)) + 1;
               2: v = (1 << (ERR_W - 1)) - 1;
               default: v = 0;
            endcase
         end
         default: v = int'($urandom);
      endcase
      return v[ERR_W-1:0];
   endfunction

   function automatic logic [SPEED_W-1:0] random_speed();
      int v;
      // half the ticks sit right around the scheduling threshold
      if ($urandom_range(0, 1)) v = int'(tracker.cfg.speed_threshold) + int'($urandom_range(0, 4)) - 2;
      else v = int'($urandom);
      return v[SPEED_W-1:0];
   endfunction

   // random bits above the register width, which the block must ignore
   function automatic logic [CSR_DATA_W-1:0] with_upper_noise(logic [CSR_DATA_W-1:0] value,
                                                              int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return ({$urandom, $urandom} & ~mask) | (value & mask);
   endfunction

   task automatic send_req(input req_type item);
      @(negedge clock);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(item);
      sent_count++;
      steady_run = (sent_count >= STEADY_FROM && sent_count < STEADY_TO);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop offering ticks and let every pending command come out
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_phase(input int ph);
      logic [3*GAIN_W-1:0] kp_t, kd_t;
      logic [4*GAIN_W-1:0] mg_t;
      logic [SPEED_W-1:0]  thr;
      logic                cl, bo;
      kp_t = {random_gain(), random_gain(), random_gain()};
      kd_t = {random_gain(), random_gain(), random_gain()};
      mg_t = {random_gain(), random_gain(), random_gain(), random_gain()};
      thr  = SPEED_W'($urandom);
      cl   = 1'b1;
      bo   = 1'b1;
      case (ph)
         1: begin
            kp_t = '1;
            kd_t = '1;
            mg_t = '1;
            thr  = '0;
         end
         2: begin
            // scheduling never active, speed error held from before
            kp_t = '0;
            kd_t = '0;
            mg_t = '0;
            thr  = '1;
            bo   = 1'b0;
         end
         3: cl = 1'b0;
         4: begin
            thr = SPEED_W'(THRESH_RESET);
            bo  = 1'b0;
         end
         default: begin
            cl = 1'($urandom_range(0, 1));
            bo = 1'($urandom_range(0, 1));
         end
      endcase
      write_csr(CSR_SERVO_KP, with_upper_noise(CSR_DATA_W'(kp_t), 3 * GAIN_W));
      write_csr(CSR_SERVO_KD, with_upper_noise(CSR_DATA_W'(kd_t), 3 * GAIN_W));
      write_csr(CSR_MOTOR_GAIN, mg_t);
      write_csr(CSR_SPEED_THRESHOLD, with_upper_noise(CSR_DATA_W'(thr), SPEED_W));
      write_csr(CSR_CLOSED_LOOP, with_upper_noise(CSR_DATA_W'(cl), 1));
      write_csr(CSR_SPEED_BOOST, with_upper_noise(CSR_DATA_W'(bo), 1));
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, {$urandom, $urandom});
   endtask

   // receiver: random stalls, plus one long hold-off so the pipeline backs up
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      req_type item;
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values only: small gains of zero, threshold 375, loops off
      for (int k = 0; k < RESET_ITEMS; k++) begin
         item.line_position = random_line();
         item.speed         = random_speed();
         send_req(item);
      end
      settle();

      write_csr(CSR_SERVO_KP, {16'h0000, 16'h0300, 16'h0200, 16'h0100});
      write_csr(CSR_SERVO_KD, {16'h0000, 16'h0400, 16'h0200, 16'h0080});
      write_csr(CSR_MOTOR_GAIN, {16'h0800, 16'h0400, 16'h0200, 16'h0100});
      write_csr(CSR_SPEED_THRESHOLD, 64'(THRESH_RESET));
      write_csr(CSR_CLOSED_LOOP, 64'd1);
      write_csr(CSR_SPEED_BOOST, 64'd1);
      // error size boundaries, speed at and just above threshold, swing extremes
      for (int k = 0; k < DIRECTED_ITEMS; k++) begin
         item.line_position = dir_pos[k][ERR_W-1:0];
         item.speed         = dir_spd[k][SPEED_W-1:0];
         send_req(item);
      end
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         program_phase(ph);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            item.line_position = random_line();
            item.speed         = random_speed();
            send_req(item);
         end
         settle();
      end

      if (tracker.mismatches == 0) begin
         $display("gain_scheduled_pd_steering_tb OK");
      end else begin
         $display("gain_scheduled_pd_steering_tb NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("gain_scheduled_pd_steering_tb NOT OK");
      $finish;
   end

endmodule
